>>> rtl/ktnrt_pkg.sv
// ----------------------------------------------------------------------------
// ktnrt_pkg: shared types for the keyed top-N ranking table
// Slot layout, field widths and the compare unit's result flags.
// ----------------------------------------------------------------------------
package ktnrt_pkg;

  localparam int unsigned KeyW   = 16;
  localparam int unsigned ValueW = 63;
  localparam int unsigned PayW   = 32;
  localparam int unsigned RankW  = 5;
  localparam int unsigned RdRankW = 4;

  // one table slot as stored in the slot memory
  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [ValueW-1:0] value;
    logic [PayW-1:0]   payload;
  } slot_t;

  // flags from the shared compare unit
  typedef struct packed {
    logic key_eq;  // submitted key equals slot key
    logic val_ge;  // submitted value is not lower than slot value
  } cmp_t;

endpackage

>>> rtl/ktnrt_if.sv
// ----------------------------------------------------------------------------
// ktnrt channel interfaces
// Valid/ready channels for submit/read requests and for their results.
// ----------------------------------------------------------------------------
interface ktnrt_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] key_id;
  logic [62:0] score_value;
  logic [31:0] payload;
  logic [3:0]  read_rank;

  modport source (output valid, operation, key_id, score_value, payload, read_rank,
                  input ready);
  modport sink (input valid, operation, key_id, score_value, payload, read_rank,
                output ready);
endinterface

interface ktnrt_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  new_rank;
  logic [4:0]  previous_rank;
  logic [62:0] previous_value;
  logic        entry_valid;
  logic [15:0] entry_key;
  logic [62:0] entry_value;
  logic [31:0] entry_payload;

  modport source (output valid, new_rank, previous_rank, previous_value, entry_valid,
                  entry_key, entry_value, entry_payload, input ready);
  modport sink (input valid, new_rank, previous_rank, previous_value, entry_valid,
                entry_key, entry_value, entry_payload, output ready);
endinterface

>>> rtl/ktnrt_slot_mem.sv
// ----------------------------------------------------------------------------
// ktnrt_slot_mem: slot storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ktnrt_slot_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic               clk_i,
  input  logic               wr_en_i,
  input  logic [AddrW-1:0]   wr_addr_i,
  input  ktnrt_pkg::slot_t   wr_data_i,
  input  logic [AddrW-1:0]   rd_addr_i,
  output ktnrt_pkg::slot_t   rd_data_o
);
  import ktnrt_pkg::*;

  slot_t mem_q [Depth];
  slot_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/ktnrt_cmp.sv
// ----------------------------------------------------------------------------
// ktnrt_cmp: shared compare unit
// Key equality and value order of the submitted item against one slot.
// ----------------------------------------------------------------------------
module ktnrt_cmp (
  input  logic [ktnrt_pkg::KeyW-1:0]   new_key_i,
  input  logic [ktnrt_pkg::ValueW-1:0] new_value_i,
  input  ktnrt_pkg::slot_t             slot_i,
  output ktnrt_pkg::cmp_t              cmp_o
);
  import ktnrt_pkg::*;

  assign cmp_o.key_eq = (new_key_i == slot_i.key);
  assign cmp_o.val_ge = (new_value_i >= slot_i.value);

endmodule

>>> rtl/keyed_top_n_ranking_table_core.sv
// ----------------------------------------------------------------------------
// keyed_top_n_ranking_table_core: keyed top-N ranking table
// Holds the best TABLE_DEPTH (key, value, payload) entries in falling value
// order, one per key; submits update the table, reads return one rank.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake      | transaction
//  ----------+-----+----------------+------------------------------------------
//  item_i    | in  | valid / ready  | submit (operation 0) or read (operation 1)
//  result_o  | out | valid / ready  | one result per accepted request
//
//  Steps: a read goes through S_READ and S_DONE to the output register. A submit
//  scans the keys one slot at a time, moves the lower slots down one at a time
//  as the new entry moves up, then writes it. The single read port of the slot
//  memory and the single compare unit make the scan and the move serial.
//  Reset: clears the fill count and control state; the table is empty after
//  reset, with no clearing pass. Stalls: item_i.ready is high only while no
//  request is in work; a result waiting on result_o does not block the next
//  request, but a finished request holds until the output register is free.
//
module keyed_top_n_ranking_table_core #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  ktnrt_in_if.sink    item_i,
  ktnrt_out_if.source result_o
);
  import ktnrt_pkg::*;

  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMPW = (CW > RdRankW) ? CW : RdRankW;
  localparam int unsigned RW   = ((AW + 1) > RankW) ? (AW + 1) : RankW;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_BUBBLE = 6'b000100,
    S_WRITE  = 6'b001000,
    S_READ   = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  typedef struct packed {
    logic [RankW-1:0]  new_rank;
    logic [RankW-1:0]  previous_rank;
    logic [ValueW-1:0] previous_value;
    logic              entry_valid;
    logic [KeyW-1:0]   entry_key;
    logic [ValueW-1:0] entry_value;
    logic [PayW-1:0]   entry_payload;
  } res_t;

  // one-based rank of a slot position, wrapped to the rank field
  function automatic logic [RankW-1:0] to_rank(logic [AW-1:0] pos);
    logic [RW-1:0] sum;
    sum = RW'(pos) + RW'(1);
    return sum[RankW-1:0];
  endfunction

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     pos_q, pos_d;
  logic              rd_hit_q, rd_hit_d;
  logic [KeyW-1:0]   key_q, key_d;
  logic [ValueW-1:0] val_q, val_d;
  logic [PayW-1:0]   pay_q, pay_d;
  res_t              res_q, res_d;
  res_t              out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  slot_t             wr_data;
  logic [AW-1:0]     rd_addr;
  slot_t             rd_data;
  cmp_t              cmp;

  logic              in_fire;
  logic              out_free;
  logic [CMPW-1:0]   rank_w;
  logic [CW-1:0]     idx_inc;
  logic              table_full;

  ktnrt_slot_mem #(
    .Depth (TABLE_DEPTH),
    .AddrW (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  ktnrt_cmp u_cmp (
    .new_key_i   (key_q),
    .new_value_i (val_q),
    .slot_i      (rd_data),
    .cmp_o       (cmp)
  );

  assign item_i.ready = (state_q == S_IDLE);
  assign in_fire      = item_i.valid && item_i.ready;
  assign out_free     = !out_valid_q || result_o.ready;
  assign rank_w       = CMPW'(item_i.read_rank);
  assign idx_inc      = CW'(pos_q) + CW'(1);
  assign table_full   = (count_q == CW'(TABLE_DEPTH));

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    rd_hit_d    = rd_hit_q;
    key_d       = key_q;
    val_d       = val_q;
    pay_d       = pay_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    wr_en       = 1'b0;
    wr_addr     = pos_q;
    wr_data     = '{key: key_q, value: val_q, payload: pay_q};
    rd_addr     = pos_q;

    // drop the output transaction once taken
    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          key_d = item_i.key_id;
          val_d = item_i.score_value;
          pay_d = item_i.payload;
          res_d = '0;
          if (item_i.operation) begin
            // rank beyond the fill count or the depth reads as empty
            rd_hit_d = (rank_w < CMPW'(count_q));
            rd_addr  = rank_w[AW-1:0];
            state_d  = S_READ;
          end else if (count_q == '0) begin
            pos_d   = '0;
            count_d = CW'(1);
            state_d = S_WRITE;
          end else begin
            pos_d   = '0;
            rd_addr = '0;
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // rd_data holds slot pos_q; valid slots always form a prefix
        if (cmp.key_eq) begin
          res_d.previous_rank  = to_rank(pos_q);
          res_d.previous_value = rd_data.value;
          if (cmp.val_ge) begin
            if (pos_q == '0) begin
              state_d = S_WRITE;
            end else begin
              rd_addr = pos_q - AW'(1);
              state_d = S_BUBBLE;
            end
          end else begin
            // not improved: keep the entry where it is
            res_d.new_rank = to_rank(pos_q);
            state_d        = S_DONE;
          end
        end else if (idx_inc == count_q) begin
          if (!table_full) begin
            // first free slot follows the last valid one
            pos_d   = count_q[AW-1:0];
            count_d = count_q + CW'(1);
            rd_addr = pos_q;
            state_d = S_BUBBLE;
          end else if (!cmp.val_ge) begin
            // lower than the last entry of a full table: leave it unchanged
            res_d.new_rank = '0;
            state_d        = S_DONE;
          end else begin
            // evict the last entry
            rd_addr = pos_q - AW'(1);
            state_d = S_BUBBLE;
          end
        end else begin
          pos_d   = idx_inc[AW-1:0];
          rd_addr = idx_inc[AW-1:0];
        end
      end

      S_BUBBLE: begin
        // rd_data holds slot pos_q - 1; move it down if not higher
        if (cmp.val_ge) begin
          wr_en   = 1'b1;
          wr_addr = pos_q;
          wr_data = rd_data;
          pos_d   = pos_q - AW'(1);
          if (pos_q == AW'(1)) begin
            state_d = S_WRITE;
          end else begin
            rd_addr = pos_q - AW'(2);
          end
        end else begin
          state_d = S_WRITE;
        end
      end

      S_WRITE: begin
        wr_en          = 1'b1;
        wr_addr        = pos_q;
        res_d.new_rank = to_rank(pos_q);
        state_d        = S_DONE;
      end

      S_READ: begin
        if (rd_hit_q) begin
          res_d.entry_valid   = 1'b1;
          res_d.entry_key     = rd_data.key;
          res_d.entry_value   = rd_data.value;
          res_d.entry_payload = rd_data.payload;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        // hold until the output register is free
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    rd_hit_q <= rd_hit_d;
    key_q    <= key_d;
    val_q    <= val_d;
    pay_q    <= pay_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.new_rank       = out_q.new_rank;
  assign result_o.previous_rank  = out_q.previous_rank;
  assign result_o.previous_value = out_q.previous_value;
  assign result_o.entry_valid    = out_q.entry_valid;
  assign result_o.entry_key      = out_q.entry_key;
  assign result_o.entry_value    = out_q.entry_value;
  assign result_o.entry_payload  = out_q.entry_payload;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the keyed top-N ranking table
// Drives submit and read transactions with random idle gaps and output
// back-pressure. A scoreboard model of the table predicts each result,
// and every result transaction is compared field by field, in order.
// ----------------------------------------------------------------------------
module testbench;
  import ktnrt_pkg::*;

  localparam int unsigned TABLE_DEPTH    = 16;
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no transaction
  localparam int unsigned LONG_STALL     = 300;   // receiver hold-off, in cycles
  localparam int unsigned DRAIN_CYCLES   = 2 * TABLE_DEPTH + 8;
  localparam logic [ValueW-1:0] SCORE_MAX = {ValueW{1'b1}};

  typedef enum logic {
    OP_SUBMIT = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  // one expected result transaction
  typedef struct packed {
    logic [RankW-1:0]  new_rank;
    logic [RankW-1:0]  previous_rank;
    logic [ValueW-1:0] previous_value;
    logic              entry_valid;
    logic [KeyW-1:0]   entry_key;
    logic [ValueW-1:0] entry_value;
    logic [PayW-1:0]   entry_payload;
  } outcome_t;

  logic clk_i;
  logic rst_ni;

  ktnrt_in_if  item_if ();
  ktnrt_out_if result_if ();

  keyed_top_n_ranking_table_core #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(result_if)
  );

  // Scoreboard copy of the ranking table: occupancy flags plus slot contents.
  bit       board_valid [TABLE_DEPTH];
  slot_t    board_slot  [TABLE_DEPTH];
  outcome_t pending_outcomes[$];
  int unsigned mismatches;

  // Handshake controls shared between the stimulus and the receiver.
  bit quiet_mode;      // no idling on either side while set
  bit long_stall_req;  // ask the receiver for one long hold-off

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Scoreboard model
  // --------------------------------------------------------------------------
  function automatic void store_entry(int idx, logic [KeyW-1:0] key,
                                      logic [ValueW-1:0] score, logic [PayW-1:0] pay);
    board_valid[idx]        = 1'b1;
    board_slot[idx].key     = key;
    board_slot[idx].value   = score;
    board_slot[idx].payload = pay;
  endfunction

  // Apply one accepted transaction to the scoreboard table and return the
  // result it must produce.
  function automatic outcome_t rank_update(op_e op, logic [KeyW-1:0] key,
                                           logic [ValueW-1:0] score,
                                           logic [PayW-1:0] pay,
                                           logic [RdRankW-1:0] rank);
    outcome_t res;
    slot_t    tmp;
    int       pos;
    int       idx;
    res = '0;

    if (op == OP_READ) begin
      if (board_valid[rank]) begin
        res.entry_valid   = 1'b1;
        res.entry_key     = board_slot[rank].key;
        res.entry_value   = board_slot[rank].value;
        res.entry_payload = board_slot[rank].payload;
      end
      return res;
    end

    // Scan for the key or the first free slot; entries are always packed
    // from rank zero, so the first free slot ends the search.
    pos = -1;
    for (idx = 0; idx < TABLE_DEPTH; idx++) begin
      if (pos < 0) begin
        if (!board_valid[idx]) begin
          store_entry(idx, key, score, pay);
          pos = idx;
        end else if (board_slot[idx].key == key) begin
          res.previous_rank  = RankW'(idx + 1);
          res.previous_value = board_slot[idx].value;
          if (board_slot[idx].value <= score) begin
            store_entry(idx, key, score, pay);
            pos = idx;
          end else begin
            // not improved: entry stays where it is
            res.new_rank = RankW'(idx + 1);
            return res;
          end
        end
      end
    end

    // Unknown key on a full table: take the last slot unless the score is lower.
    if (pos < 0) begin
      if (score < board_slot[TABLE_DEPTH-1].value) return res;
      pos = TABLE_DEPTH - 1;
      store_entry(pos, key, score, pay);
    end

    // Bubble up past every entry of equal or lower score.
    while (pos > 0 && score >= board_slot[pos-1].value) begin
      tmp                 = board_slot[pos-1];
      board_slot[pos-1]   = board_slot[pos];
      board_slot[pos]     = tmp;
      pos--;
    end
    res.new_rank = RankW'(pos + 1);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [ValueW-1:0] rand_score();
    logic [ValueW-1:0] s;
    case ($urandom_range(0, 4))
      0:       s = ValueW'($urandom_range(0, 7));  // dense: plenty of ties
      1:       s = ValueW'($urandom_range(0, 1000));
      2: begin
        case ($urandom_range(0, 2))
          0:       s = '0;
          1:       s = SCORE_MAX;
          default: s = SCORE_MAX - 1;
        endcase
      end
      default: s = ValueW'({$urandom(), $urandom()});
    endcase
    return s;
  endfunction

  // Send one request transaction. Called and returns at a falling edge; the
  // valid is left high so that a back-to-back request never toggles it twice
  // in one time step.
  task automatic issue_request(op_e op, logic [KeyW-1:0] key,
                               logic [ValueW-1:0] score, logic [PayW-1:0] pay,
                               logic [RdRankW-1:0] rank);
    while (!quiet_mode && $urandom_range(0, 99) < 8) begin
      item_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    item_if.valid       <= 1'b1;
    item_if.operation   <= op;
    item_if.key_id      <= key;
    item_if.score_value <= score;
    item_if.payload     <= pay;
    item_if.read_rank   <= rank;
    do @(posedge clk_i); while (!item_if.ready);
    pending_outcomes.push_back(rank_update(op, key, score, pay, rank));
    @(negedge clk_i);
  endtask

  // Fields that the operation ignores still get random values.
  task automatic submit_score(logic [KeyW-1:0] key, logic [ValueW-1:0] score,
                              logic [PayW-1:0] pay);
    issue_request(OP_SUBMIT, key, score, pay, RdRankW'($urandom_range(0, 15)));
  endtask

  task automatic read_rank_at(logic [RdRankW-1:0] rank);
    issue_request(OP_READ, KeyW'($urandom()), ValueW'({$urandom(), $urandom()}),
                  $urandom(), rank);
  endtask

  // Mostly keys from a small pool so that known-key updates and evictions
  // are frequent; now and then any key at all.
  task automatic random_traffic(int unsigned count, int unsigned key_base);
    logic [KeyW-1:0] key;
    repeat (count) begin
      if ($urandom_range(0, 9) == 0) key = KeyW'($urandom());
      else key = KeyW'(key_base + $urandom_range(0, 23));
      if ($urandom_range(0, 3) == 0) read_rank_at(RdRankW'($urandom_range(0, 15)));
      else submit_score(key, rand_score(), $urandom());
    end
  endtask

  // --------------------------------------------------------------------------
  // Test tasks
  // --------------------------------------------------------------------------
  task automatic test_empty_reads();
    read_rank_at(4'd0);
    read_rank_at(4'd15);
  endtask

  // Extremes, ties, and known keys with lower and equal scores.
  task automatic test_submit_rules();
    submit_score(16'h0000, '0, 32'h0000_0000);
    submit_score(16'hFFFF, SCORE_MAX, 32'hFFFF_FFFF);
    submit_score(16'h0005, SCORE_MAX, 32'h1234_5678);  // tie: goes on top
    submit_score(16'hFFFF, 63'd100, 32'hDEAD_BEEF);    // lower: keeps its place
    submit_score(16'hFFFF, SCORE_MAX, 32'hA5A5_A5A5);  // equal: rewritten, moves up
    submit_score(16'h0000, '0, 32'hFFFF_FFFF);
    read_rank_at(4'd2);
    read_rank_at(4'd3);
  endtask

  // Fill the table, then evict the last entry and get rejected below it.
  task automatic test_full_table();
    for (int unsigned i = 0; i < TABLE_DEPTH - 3; i++)
      submit_score(KeyW'(16'h0100 + i), ValueW'(1000 - 10 * i), $urandom());
    submit_score(16'h0200, 63'd50, 32'h0000_0050);  // evicts the zero entry
    submit_score(16'h0201, 63'd49, 32'h0000_0049);  // lower than last: rejected
    submit_score(16'h0202, 63'd50, 32'h0000_0051);  // equal to last: evicts it
    read_rank_at(4'd15);
  endtask

  task automatic test_random_no_idle();
    quiet_mode = 1'b1;
    random_traffic(500, 16'h0200);
    quiet_mode = 1'b0;
  endtask

  // Hold the result side off for a long stretch while requests keep coming,
  // so the output register fills and the input stalls.
  task automatic test_output_backpressure();
    long_stall_req = 1'b1;
    random_traffic(12, 16'h0200);
  endtask

  task automatic test_random_idling();
    random_traffic(700, 16'h0200);
    random_traffic(700, 16'h7F00);  // new key pool: forces wholesale eviction
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off when asked
  // --------------------------------------------------------------------------
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        result_if.ready <= 1'b0;
        repeat (LONG_STALL) @(negedge clk_i);
      end
      result_if.ready <= quiet_mode || ($urandom_range(0, 99) >= 8);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: compare each result transaction with the oldest prediction
  // --------------------------------------------------------------------------
  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (pending_outcomes.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none", $time);
        mismatches++;
      end else begin
        want = pending_outcomes.pop_front();
        check_field("new_rank", 64'(want.new_rank), 64'(result_if.new_rank));
        check_field("previous_rank", 64'(want.previous_rank),
                    64'(result_if.previous_rank));
        check_field("previous_value", 64'(want.previous_value),
                    64'(result_if.previous_value));
        check_field("entry_valid", 64'(want.entry_valid), 64'(result_if.entry_valid));
        check_field("entry_key", 64'(want.entry_key), 64'(result_if.entry_key));
        check_field("entry_value", 64'(want.entry_value), 64'(result_if.entry_value));
        check_field("entry_payload", 64'(want.entry_payload),
                    64'(result_if.entry_payload));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if no transaction moves for too long
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned dead_cycles;
    dead_cycles = 0;
    while (dead_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
        dead_cycles = 0;
      else
        dead_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    mismatches           = 0;
    quiet_mode           = 1'b0;
    long_stall_req       = 1'b0;
    rst_ni               = 1'b0;
    item_if.valid        = 1'b0;
    item_if.operation    = OP_SUBMIT;
    item_if.key_id       = '0;
    item_if.score_value  = '0;
    item_if.payload      = '0;
    item_if.read_rank    = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      board_valid[i] = 1'b0;
      board_slot[i]  = '0;
    end

    // Hold reset, then release it on a falling edge.
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_reads();
    test_submit_rules();
    test_full_table();
    test_random_no_idle();
    test_output_backpressure();
    test_random_idling();

    // Drop valid, drain the outstanding results, then give the block time
    // to show any stray result.
    item_if.valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending_outcomes.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
